// File: rtl/lkvt_pkg.sv
// shared types and constants for the linear key/value table
// no dependencies; imported by every other file in rtl
package lkvt_pkg;

    // fixed widths of the item fields at the ports
    localparam int KIND_W    = 3;
    localparam int KEY_IN_W  = 32;
    localparam int VAL_IN_W  = 32;
    localparam int SLOT_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 9;

    // defaults for the top level parameters
    localparam int CAPACITY_DEF    = 256;
    localparam int KEY_WIDTH_DEF   = 32;
    localparam int VALUE_WIDTH_DEF = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT      = 3'd0,
        KIND_LOOKUP      = 3'd1,
        KIND_REMOVE_KEY  = 3'd2,
        KIND_READ_SLOT   = 3'd3,
        KIND_REMOVE_SLOT = 3'd4
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_RANGE     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_SLOT_WAIT,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_RESULT
    } t_state;

    // one result item as it leaves the sequencer
    typedef struct packed {
        t_status               status;
        logic                  found;
        logic [KEY_IN_W-1:0]   key_out;
        logic [VAL_IN_W-1:0]   value_out;
        logic [COUNT_W-1:0]    count;
        logic                  empty_res;
    } t_result;

endpackage

// File: rtl/lkvt_ram.sv
// pair storage: one write port, one read port with registered read data
// depends on lkvt_pkg for default sizes
module lkvt_ram
    import lkvt_pkg::*;
#(
    parameter int DEPTH = CAPACITY_DEF,
    parameter int WIDTH = KEY_WIDTH_DEF + VALUE_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/lkvt_seq.sv
// request sequencer: decodes an item, scans slots through the shared key compare,
// moves the last pair into a freed slot and holds the entry count; uses lkvt_pkg
module lkvt_seq
    import lkvt_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    localparam int AW   = $clog2(CAPACITY),
    localparam int KS_W = (KEY_WIDTH < KEY_IN_W) ? KEY_WIDTH : KEY_IN_W,
    localparam int VS_W = (VALUE_WIDTH < VAL_IN_W) ? VALUE_WIDTH : VAL_IN_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [KIND_W-1:0]    i_kind,
    input  logic [KEY_IN_W-1:0]  i_key_in,
    input  logic [VAL_IN_W-1:0]  i_value_in,
    input  logic [SLOT_W-1:0]    i_slot_in,
    // storage port
    output logic                 o_we,
    output logic [AW-1:0]        o_waddr,
    output logic [KS_W+VS_W-1:0] o_wdata,
    output logic [AW-1:0]        o_raddr,
    input  logic [KS_W+VS_W-1:0] i_rdata,
    // result handoff
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output t_result              o_res
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = (CW > SLOT_W) ? CW : SLOT_W;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_issue, n_issue;
    logic              r_pend, n_pend;
    logic [AW-1:0]     r_pend_idx, n_pend_idx;
    logic [AW-1:0]     r_hit_idx, n_hit_idx;
    t_kind             r_kind, n_kind;
    logic [KS_W-1:0]   r_key, n_key;
    logic [VS_W-1:0]   r_val, n_val;
    logic [SLOT_W-1:0] r_slot, n_slot;
    t_status           r_status, n_status;
    logic              r_found, n_found;
    logic [KEY_IN_W-1:0] r_kout, n_kout;
    logic [VAL_IN_W-1:0] r_vout, n_vout;

    logic              accept;
    logic              full;
    logic              slot_bad;
    logic [AW-1:0]     slot_addr;
    logic [CW-1:0]     last_cnt;
    logic [KS_W-1:0]   rd_key;
    logic [VS_W-1:0]   rd_val;
    logic              scan_hit;
    logic              scan_miss;
    logic              issue_more;

    assign accept     = i_in_valid && !o_in_stall;
    assign full       = (r_count == CW'(CAPACITY));
    assign slot_bad   = (SW'(r_slot) >= SW'(r_count));
    assign slot_addr  = AW'(r_slot);
    assign last_cnt   = r_count - CW'(1);
    assign rd_key     = i_rdata[KS_W+VS_W-1:VS_W];
    assign rd_val     = i_rdata[VS_W-1:0];
    // shared compare: data read last cycle against the wanted key
    assign scan_hit   = r_pend && (rd_key == r_key);
    assign issue_more = (r_issue < r_count);
    assign scan_miss  = !r_pend && !issue_more;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                unique case (r_kind)
                    KIND_LOOKUP, KIND_REMOVE_KEY: n_state = ST_SCAN;
                    KIND_READ_SLOT, KIND_REMOVE_SLOT: begin
                        n_state = slot_bad ? ST_RESULT : ST_SLOT_WAIT;
                    end
                    default: n_state = ST_RESULT;
                endcase
            end
            ST_SCAN: begin
                if (scan_hit) begin
                    n_state = (r_kind == KIND_REMOVE_KEY) ? ST_MOVE_RD : ST_RESULT;
                end else if (scan_miss) begin
                    n_state = ST_RESULT;
                end
            end
            ST_SLOT_WAIT: begin
                n_state = (r_kind == KIND_REMOVE_SLOT) ? ST_MOVE_RD : ST_RESULT;
            end
            ST_MOVE_RD: n_state = ST_MOVE_WR;
            ST_MOVE_WR: n_state = ST_RESULT;
            ST_RESULT: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and storage control
    always_comb begin
        n_count    = r_count;
        n_issue    = r_issue;
        n_pend     = r_pend;
        n_pend_idx = r_pend_idx;
        n_hit_idx  = r_hit_idx;
        n_kind     = r_kind;
        n_key      = r_key;
        n_val      = r_val;
        n_slot     = r_slot;
        n_status   = r_status;
        n_found    = r_found;
        n_kout     = r_kout;
        n_vout     = r_vout;
        o_we       = 1'b0;
        o_waddr    = AW'(r_count);
        o_wdata    = {r_key, r_val};
        o_raddr    = AW'(r_issue);
        o_res_valid = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_kind = t_kind'(i_kind);
                    n_key  = i_key_in[KS_W-1:0];
                    n_val  = i_value_in[VS_W-1:0];
                    n_slot = i_slot_in;
                end
            end
            ST_DISPATCH: begin
                n_status  = STAT_OK;
                n_found   = 1'b0;
                n_kout    = '0;
                n_vout    = '0;
                n_issue   = '0;
                n_pend    = 1'b0;
                n_hit_idx = slot_addr;
                // read at slot issues its read now, data comes back next cycle
                o_raddr   = slot_addr;
                unique case (r_kind)
                    KIND_INSERT: begin
                        if (full) begin
                            n_status = STAT_FULL;
                        end else begin
                            o_we    = 1'b1;
                            n_count = r_count + CW'(1);
                        end
                    end
                    KIND_READ_SLOT, KIND_REMOVE_SLOT: begin
                        if (slot_bad) begin
                            n_status = STAT_RANGE;
                        end
                    end
                    default: ;
                endcase
            end
            ST_SCAN: begin
                if (scan_hit) begin
                    n_found   = 1'b1;
                    n_kout    = KEY_IN_W'(rd_key);
                    n_vout    = VAL_IN_W'(rd_val);
                    n_hit_idx = r_pend_idx;
                end else if (scan_miss) begin
                    n_status = STAT_NOT_FOUND;
                end else begin
                    // one slot read per cycle, compared once its registered read data returns
                    n_pend     = issue_more;
                    n_pend_idx = AW'(r_issue);
                    if (issue_more) begin
                        n_issue = r_issue + CW'(1);
                    end
                end
            end
            ST_SLOT_WAIT: begin
                n_found = 1'b1;
                n_kout  = KEY_IN_W'(rd_key);
                n_vout  = VAL_IN_W'(rd_val);
            end
            ST_MOVE_RD: begin
                o_raddr = AW'(last_cnt);
            end
            ST_MOVE_WR: begin
                // last pair fills the freed slot
                o_we    = 1'b1;
                o_waddr = r_hit_idx;
                o_wdata = i_rdata;
                n_count = last_cnt;
            end
            ST_RESULT: begin
                o_res_valid = 1'b1;
            end
            default: ;
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        o_res.status    = r_status;
        o_res.found     = r_found;
        o_res.key_out   = r_kout;
        o_res.value_out = r_vout;
        o_res.count     = COUNT_W'(r_count);
        o_res.empty_res = (r_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_issue    <= n_issue;
        r_pend     <= n_pend;
        r_pend_idx <= n_pend_idx;
        r_hit_idx  <= n_hit_idx;
        r_kind     <= n_kind;
        r_key      <= n_key;
        r_val      <= n_val;
        r_slot     <= n_slot;
        r_status   <= n_status;
        r_found    <= n_found;
        r_kout     <= n_kout;
        r_vout     <= n_vout;
    end

endmodule

// File: rtl/linear_key_value_table_core.sv
// linear key/value table: pairs packed in slots 0..count-1, searched one slot a cycle
// insert, unknown kind or bad slot go from dispatch straight to the result; read at slot waits for its data
// by key: the scan reads slot after slot through the single read port until a hit or the end
// of the table; removals then move the last pair into the freed slot, a read state and a write state
// one item at a time, next accept once the result loads; reset empties table at once
// depends on lkvt_pkg, lkvt_ram, lkvt_seq
module linear_key_value_table_core
    import lkvt_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [KEY_IN_W-1:0] i_key_in,
    input  logic [VAL_IN_W-1:0] i_value_in,
    input  logic [SLOT_W-1:0]   i_slot_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_found,
    output logic [KEY_IN_W-1:0] o_key_out,
    output logic [VAL_IN_W-1:0] o_value_out,
    output logic [COUNT_W-1:0]  o_count,
    output logic                o_empty_res
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int KS_W = (KEY_WIDTH < KEY_IN_W) ? KEY_WIDTH : KEY_IN_W;
    localparam int VS_W = (VALUE_WIDTH < VAL_IN_W) ? VALUE_WIDTH : VAL_IN_W;

    logic                 we;
    logic [AW-1:0]        waddr;
    logic [KS_W+VS_W-1:0] wdata;
    logic [AW-1:0]        raddr;
    logic [KS_W+VS_W-1:0] rdata;
    logic                 res_valid;
    logic                 res_ready;
    t_result              res;

    logic                 r_out_valid;
    t_result              r_out;

    lkvt_seq #(
        .CAPACITY    (CAPACITY),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_key_in    (i_key_in),
        .i_value_in  (i_value_in),
        .i_slot_in   (i_slot_in),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    lkvt_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (KS_W + VS_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // output register, refilled in the cycle its item is taken
    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out.status;
    assign o_found     = r_out.found;
    assign o_key_out   = r_out.key_out;
    assign o_value_out = r_out.value_out;
    assign o_count     = r_out.count;
    assign o_empty_res = r_out.empty_res;

    // one item at a time: no second accept right behind the first
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken while previous item still in work");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == STAT_FULL) |-> (o_count == COUNT_W'(CAPACITY)))
        else $error("table full reported below capacity");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> (o_status == STAT_OK))
        else $error("found with error status");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == STAT_NOT_FOUND || o_status == STAT_RANGE))
        |-> (!o_found && o_key_out == '0 && o_value_out == '0))
        else $error("miss carries pair data");

endmodule

// File: sim/tb_linear_key_value_table_core.sv
// testbench for linear_key_value_table_core: random and directed table requests, results
// checked against a behavioral mirror of the table held in a small scoreboard class
// depends on rtl/lkvt_pkg.sv and the rtl of linear_key_value_table_core
`timescale 1ns / 1ps

import lkvt_pkg::*;

class kv_table_mirror;
    logic [KEY_IN_W-1:0] keys [CAPACITY_DEF];
    logic [VAL_IN_W-1:0] vals [CAPACITY_DEF];
    int unsigned         n_pairs;
    t_result             pending [$];
    int unsigned         errors;

    function new();
        n_pairs = 0;
        errors  = 0;
    endfunction

    // last pair fills the freed slot
    function void drop_pair(int unsigned s);
        keys[s] = keys[n_pairs-1];
        vals[s] = vals[n_pairs-1];
        n_pairs--;
    endfunction

    function void note_request(logic [KIND_W-1:0] kind, logic [KEY_IN_W-1:0] key,
                               logic [VAL_IN_W-1:0] value, logic [SLOT_W-1:0] slot);
        t_result r;
        int      hit;
        r = '0;
        r.status = STAT_OK;
        hit = -1;
        case (kind)
            KIND_INSERT: begin
                if (n_pairs >= CAPACITY_DEF) begin
                    r.status = STAT_FULL;
                end else begin
                    keys[n_pairs] = key;
                    vals[n_pairs] = value;
                    n_pairs++;
                end
            end
            KIND_LOOKUP, KIND_REMOVE_KEY: begin
                for (int i = 0; i < n_pairs; i++) begin
                    if (keys[i] == key) begin
                        hit = i;
                        break;
                    end
                end
                if (hit < 0) begin
                    r.status = STAT_NOT_FOUND;
                end else begin
                    r.found     = 1'b1;
                    r.key_out   = keys[hit];
                    r.value_out = vals[hit];
                    if (kind == KIND_REMOVE_KEY) drop_pair(hit);
                end
            end
            KIND_READ_SLOT, KIND_REMOVE_SLOT: begin
                if (slot >= n_pairs) begin
                    r.status = STAT_RANGE;
                end else begin
                    r.found     = 1'b1;
                    r.key_out   = keys[slot];
                    r.value_out = vals[slot];
                    if (kind == KIND_REMOVE_SLOT) drop_pair(slot);
                end
            end
            default: ;
        endcase
        r.count     = COUNT_W'(n_pairs);
        r.empty_res = (n_pairs == 0);
        pending.push_back(r);
    endfunction

    function void check_reply(logic [STATUS_W-1:0] status, logic found,
                              logic [KEY_IN_W-1:0] key, logic [VAL_IN_W-1:0] value,
                              logic [COUNT_W-1:0] count, logic empty);
        t_result e;
        bit      bad;
        bad = 1'b0;
        if (pending.size() == 0) begin
            $error("result item with no request waiting: status %0d count %0d",
                   status, count);
            errors++;
        end else begin
            e = pending.pop_front();
            if (e.status !== status) begin
                $error("status: expected %0d, got %0d", e.status, status);
                bad = 1'b1;
            end
            if (e.found !== found) begin
                $error("found: expected %0d, got %0d", e.found, found);
                bad = 1'b1;
            end
            if (e.key_out !== key) begin
                $error("key_out: expected %h, got %h", e.key_out, key);
                bad = 1'b1;
            end
            if (e.value_out !== value) begin
                $error("value_out: expected %h, got %h", e.value_out, value);
                bad = 1'b1;
            end
            if (e.count !== count) begin
                $error("count: expected %0d, got %0d", e.count, count);
                bad = 1'b1;
            end
            if (e.empty_res !== empty) begin
                $error("empty_res: expected %0d, got %0d", e.empty_res, empty);
                bad = 1'b1;
            end
            if (bad) errors++;
        end
    endfunction
endclass

module tb_linear_key_value_table_core;

    localparam int TABLE_DEPTH = CAPACITY_DEF;
    localparam int HOLD_CYCLES = 300;
    localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    logic [KIND_W-1:0]   i_kind      = '0;
    logic [KEY_IN_W-1:0] i_key_in    = '0;
    logic [VAL_IN_W-1:0] i_value_in  = '0;
    logic [SLOT_W-1:0]   i_slot_in   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic                o_found;
    logic [KEY_IN_W-1:0] o_key_out;
    logic [VAL_IN_W-1:0] o_value_out;
    logic [COUNT_W-1:0]  o_count;
    logic                o_empty_res;

    kv_table_mirror      mirror = new();
    logic [KEY_IN_W-1:0] key_pool [8];
    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;
    int                  hold_seq  = 0;
    int                  hold_seen = 0;
    int                  hold_left = 0;

    linear_key_value_table_core #(
        .CAPACITY    (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH_DEF),
        .VALUE_WIDTH (VALUE_WIDTH_DEF)
    ) uut (.*);

    always #2 i_clk = ~i_clk;

    // receiver: long hold-off on request, otherwise random stalls
    always @(posedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            mirror.check_reply(o_status, o_found, o_key_out, o_value_out, o_count, o_empty_res);
    end

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [KEY_IN_W-1:0] key,
                             input logic [VAL_IN_W-1:0] value, input logic [SLOT_W-1:0] slot);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_key_in   <= key;
        i_value_in <= value;
        i_slot_in  <= slot;
        do @(posedge i_clk); while (o_in_stall);
        mirror.note_request(kind, key, value, slot);
    endtask

    // sender pauses until every result item is back
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (mirror.pending.size() != 0);
    endtask

    function automatic logic [KEY_IN_W-1:0] pool_key();
        if ($urandom_range(99) < 75) return key_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    // mostly keys that are stored, so scans hit at every depth
    function automatic logic [KEY_IN_W-1:0] pick_key();
        if (mirror.n_pairs != 0 && $urandom_range(99) < 80)
            return mirror.keys[$urandom_range(mirror.n_pairs - 1)];
        return pool_key();
    endfunction

    function automatic logic [SLOT_W-1:0] pick_slot();
        if (mirror.n_pairs != 0 && $urandom_range(99) < 80)
            return SLOT_W'($urandom_range(mirror.n_pairs - 1));
        return SLOT_W'($urandom_range(255));
    endfunction

    task automatic send_random(input int n);
        logic [KIND_W-1:0]   kind;
        logic [KEY_IN_W-1:0] key;
        logic [SLOT_W-1:0]   slot;
        int                  r;
        for (int i = 0; i < n; i++) begin
            r    = $urandom_range(99);
            key  = pick_key();
            slot = pick_slot();
            if (r < 28) begin
                kind = KIND_INSERT;
                key  = pool_key();
            end else if (r < 46) begin
                kind = KIND_LOOKUP;
            end else if (r < 60) begin
                kind = KIND_REMOVE_KEY;
            end else if (r < 74) begin
                kind = KIND_READ_SLOT;
            end else if (r < 88) begin
                kind = KIND_REMOVE_SLOT;
            end else if (r < 93) begin
                kind = KIND_SPARE_FIRST + KIND_W'($urandom_range(2));
            end else begin
                // anything at all in every field
                kind = KIND_W'($urandom_range(7));
                key  = $urandom;
                slot = SLOT_W'($urandom);
            end
            send_item(kind, key, $urandom, slot);
        end
    endtask

    initial begin
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < 8; i++) key_pool[i] = $urandom;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table: misses, bad slots, unused kinds
        send_item(KIND_LOOKUP, '0, '0, '0);
        send_item(KIND_REMOVE_KEY, '1, '0, '0);
        send_item(KIND_READ_SLOT, '0, '0, '0);
        send_item(KIND_REMOVE_SLOT, '0, '0, '1);
        send_item(KIND_SPARE_FIRST, '1, '1, '1);
        send_item(KIND_SPARE_FIRST + 3'd1, '1, '1, '1);
        send_item(KIND_SPARE_LAST, '1, '1, '1);
        // a few pairs with a duplicate key
        send_item(KIND_INSERT, '0, '0, '1);
        send_item(KIND_INSERT, '1, '1, '0);
        send_item(KIND_INSERT, 32'h8000_0001, 32'h7fff_fffe, '0);
        send_item(KIND_INSERT, '0, 32'h0000_0001, '0);
        send_item(KIND_LOOKUP, '0, '1, '1);
        send_item(KIND_LOOKUP, '1, '0, '0);
        send_item(KIND_READ_SLOT, '0, '0, 8'd3);
        send_item(KIND_READ_SLOT, '0, '0, 8'd4);
        // first match goes, the last pair moves into slot 0
        send_item(KIND_REMOVE_KEY, '0, '0, '0);
        send_item(KIND_LOOKUP, '0, '0, '0);
        send_item(KIND_REMOVE_SLOT, '0, '0, 8'd2);
        send_item(KIND_REMOVE_SLOT, '0, '0, 8'd0);
        send_item(KIND_READ_SLOT, '0, '0, 8'd0);
        send_item(KIND_REMOVE_KEY, '1, '0, '0);
        send_item(KIND_READ_SLOT, '0, '0, 8'd0);
        drain();

        // block fills up and stalls its input while the output is held off
        hold_seq <= hold_seq + 1;
        send_random(130);

        // fill to capacity, then the full table and its last slot
        while (mirror.n_pairs < TABLE_DEPTH)
            send_item(KIND_INSERT, pool_key(), $urandom, SLOT_W'($urandom));
        repeat (4) send_item(KIND_INSERT, pool_key(), $urandom, SLOT_W'($urandom));
        send_item(KIND_READ_SLOT, '0, '0, 8'd255);
        send_item(KIND_LOOKUP, mirror.keys[TABLE_DEPTH-1], '0, '0);
        send_item(KIND_REMOVE_SLOT, '0, '0, 8'd255);
        send_item(KIND_INSERT, $urandom, $urandom, '0);
        send_item(KIND_REMOVE_SLOT, '0, '0, 8'd0);
        send_random(20);
        drain();

        send_idle_pct = 87;
        send_random(130);
        drain();

        send_idle_pct = 0;
        recv_stall_pct <= 87;
        send_random(130);
        drain();

        send_idle_pct = 34;
        recv_stall_pct <= 34;
        send_random(130);
        drain();

        repeat (TABLE_DEPTH + 16) @(posedge i_clk);
        if (mirror.errors == 0 && mirror.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
